// ===== src/rlfrt_pkg.sv =====
package rlfrt_pkg;

    localparam int FIRST_W     = 13;
    localparam int SECOND_W    = 15;
    localparam int REMAIN_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;

    localparam logic [FIRST_W-1:0]  FIRST_RESET  = 13'd2000;
    localparam logic [SECOND_W-1:0] SECOND_RESET = 15'd3000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_TIMEOUT = 2'd1;

    // Failure cause codes as they arrive on the input.
    localparam logic [1:0] FCAUSE_MAC   = 2'd0;
    localparam logic [1:0] FCAUSE_RETX  = 2'd1;
    localparam logic [1:0] FCAUSE_PROTO = 2'd2;

    // Release cause codes on the output.
    localparam logic REL_MAC  = 1'b0;
    localparam logic REL_LINK = 1'b1;

    // Bit positions of the result fields in m_tdata.
    localparam int OUT_REQ_BIT     = 0;
    localparam int OUT_CAUSE_BIT   = 1;
    localparam int OUT_STOP_BIT    = 2;
    localparam int OUT_DISDONE_BIT = 3;
    localparam int OUT_COUNT_BIT   = 4;
    localparam int OUT_ACTIVE_BIT  = 5;
    localparam int OUT_STORED_LSB  = 6;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_FAIL    = 2'd1,
        KIND_RECOVER = 2'd2,
        KIND_DISABLE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_MAC   = 2'd1,
        CAUSE_RETX  = 2'd2,
        CAUSE_PROTO = 2'd3
    } cause_t;

    typedef struct packed {
        logic [FIRST_W-1:0]  first_timeout_ms;
        logic [SECOND_W-1:0] second_timeout_ms;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] failure_cause;
        logic       bearers_ready;
    } item_t;

    typedef struct packed {
        logic       release_request;
        logic       release_cause;
        logic       stop_traffic;
        logic       disable_done;
        logic       counting;
        logic       active_flag;
        cause_t     stored_cause;
    } result_t;

    function automatic logic [OUT_DATA_W-1:0] pack_result(result_t r);
        logic [OUT_DATA_W-1:0] d;
        d = '0;
        d[OUT_REQ_BIT]                      = r.release_request;
        d[OUT_CAUSE_BIT]                    = r.release_cause;
        d[OUT_STOP_BIT]                     = r.stop_traffic;
        d[OUT_DISDONE_BIT]                  = r.disable_done;
        d[OUT_COUNT_BIT]                    = r.counting;
        d[OUT_ACTIVE_BIT]                   = r.active_flag;
        d[OUT_STORED_LSB+1:OUT_STORED_LSB]  = r.stored_cause;
        return d;
    endfunction

endpackage

// ===== src/radio_link_failure_release_timer_top.sv =====
// Radio link failure supervision for one user. Items on the s_ side are
// millisecond ticks, failure reports, recovery notices and disables; each one
// gives exactly one result item on the m_ side, in order. The block takes one
// item per clock cycle while m_tready is high. Each item is held in the input
// register while the combinational update of the supervision state works on
// it, then the result register takes the outcome and drives the m_ side. While
// a finished result waits on m_tready the input register can still take one
// item, after which s_tready stays low until the result drains. Timeouts are
// written over the cfg channel, which is always ready, and must only be
// changed while no item is in flight. Reset enables supervision with no
// countdown running.
module radio_link_failure_release_timer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] failure_cause, [2] bearers_ready, [7:3] zero
    input  logic [rlfrt_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [rlfrt_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] release_request, [1] release_cause, [2] stop_traffic,
    // [3] disable_done, [4] counting, [5] active_flag, [7:6] stored_cause
    output logic [rlfrt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlfrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlfrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rlfrt_pkg::cfg_t    cfg;
    rlfrt_pkg::item_t   in_item_reg;
    rlfrt_pkg::result_t core_result;
    rlfrt_pkg::result_t out_res_reg;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               advance;
    logic               in_fire;

    rlfrt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlfrt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .result  (core_result)
    );

    // The held item moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.kind          <= rlfrt_pkg::kind_t'(s_tuser);
            in_item_reg.failure_cause <= s_tdata[1:0];
            in_item_reg.bearers_ready <= s_tdata[2];
        end
        if (advance)
        begin
            out_res_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rlfrt_pkg::pack_result(out_res_reg);

endmodule

// ===== src/rlfrt_cfg_regs.sv =====
module rlfrt_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlfrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlfrt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rlfrt_pkg::cfg_t                   cfg
);

    logic [rlfrt_pkg::FIRST_W-1:0]  first_reg;
    logic [rlfrt_pkg::SECOND_W-1:0] second_reg;
    logic                           wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= rlfrt_pkg::FIRST_RESET;
            second_reg <= rlfrt_pkg::SECOND_RESET;
        end
        else if (wr_en)
        begin
            if (cfg_index == rlfrt_pkg::REG_FIRST_TIMEOUT)
            begin
                first_reg <= cfg_data[rlfrt_pkg::FIRST_W-1:0];
            end
            else if (cfg_index == rlfrt_pkg::REG_SECOND_TIMEOUT)
            begin
                second_reg <= cfg_data[rlfrt_pkg::SECOND_W-1:0];
            end
        end
    end

    assign cfg.first_timeout_ms  = first_reg;
    assign cfg.second_timeout_ms = second_reg;

endmodule

// ===== src/rlfrt_core.sv =====
module rlfrt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  rlfrt_pkg::cfg_t     cfg,
    input  rlfrt_pkg::item_t    item,
    input  logic                advance,
    output rlfrt_pkg::result_t  result
);

    logic                              enabled_reg, enabled_next;
    logic                              running_reg, running_next;
    rlfrt_pkg::cause_t                 held_reg, held_next;
    logic [rlfrt_pkg::REMAIN_W-1:0]    remain_reg, remain_next;
    logic [rlfrt_pkg::REMAIN_W-1:0]    load_value;
    logic                              held_is_link;
    logic                              cause_valid;
    rlfrt_pkg::cause_t                 new_cause;

    assign held_is_link = (held_reg == rlfrt_pkg::CAUSE_RETX) ||
                          (held_reg == rlfrt_pkg::CAUSE_PROTO);
    assign cause_valid  = (item.failure_cause == rlfrt_pkg::FCAUSE_MAC) ||
                          (item.failure_cause == rlfrt_pkg::FCAUSE_RETX) ||
                          (item.failure_cause == rlfrt_pkg::FCAUSE_PROTO);
    assign new_cause    = rlfrt_pkg::cause_t'(item.failure_cause + 2'd1);

    // The sum of both timeouts always fits in the countdown width.
    assign load_value = item.bearers_ready ?
        (rlfrt_pkg::REMAIN_W'(cfg.first_timeout_ms) +
         rlfrt_pkg::REMAIN_W'(cfg.second_timeout_ms)) :
        rlfrt_pkg::REMAIN_W'(cfg.first_timeout_ms);

    always_comb
    begin
        enabled_next = enabled_reg;
        running_next = running_reg;
        held_next    = held_reg;
        remain_next  = remain_reg;
        result       = '0;

        case (item.kind)
            rlfrt_pkg::KIND_TICK:
            begin
                if (enabled_reg && running_reg)
                begin
                    if (remain_reg <= rlfrt_pkg::REMAIN_W'(1))
                    begin
                        remain_next            = '0;
                        result.release_request = 1'b1;
                        result.release_cause   = (held_reg == rlfrt_pkg::CAUSE_MAC) ?
                                                 rlfrt_pkg::REL_MAC : rlfrt_pkg::REL_LINK;
                        running_next           = 1'b0;
                        enabled_next           = 1'b0;
                    end
                    else
                    begin
                        remain_next = remain_reg - rlfrt_pkg::REMAIN_W'(1);
                    end
                end
            end
            rlfrt_pkg::KIND_FAIL:
            begin
                if (cause_valid && enabled_reg && !held_is_link)
                begin
                    if (running_reg)
                    begin
                        // A link-layer cause overrides a MAC cause mid-countdown.
                        if (new_cause != rlfrt_pkg::CAUSE_MAC &&
                            held_reg == rlfrt_pkg::CAUSE_MAC)
                        begin
                            held_next           = new_cause;
                            result.stop_traffic = 1'b1;
                        end
                    end
                    else
                    begin
                        held_next           = new_cause;
                        remain_next         = load_value;
                        running_next        = 1'b1;
                        result.stop_traffic = (new_cause != rlfrt_pkg::CAUSE_MAC);
                    end
                end
            end
            rlfrt_pkg::KIND_RECOVER:
            begin
                if (running_reg && held_reg == rlfrt_pkg::CAUSE_MAC)
                begin
                    running_next = 1'b0;
                end
            end
            default:
            begin
                if (enabled_reg)
                begin
                    enabled_next        = 1'b0;
                    running_next        = 1'b0;
                    result.disable_done = 1'b1;
                end
            end
        endcase

        result.counting     = running_next;
        result.active_flag  = enabled_next;
        result.stored_cause = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            running_reg <= 1'b0;
            held_reg    <= rlfrt_pkg::CAUSE_NONE;
            remain_reg  <= '0;
        end
        else if (advance)
        begin
            enabled_reg <= enabled_next;
            running_reg <= running_next;
            held_reg    <= held_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ===== src/rlfrt_checker.sv =====
module rlfrt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rlfrt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // A result that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A release leaves supervision off and the countdown stopped.
    a_release_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[rlfrt_pkg::OUT_REQ_BIT] |->
            !m_tdata[rlfrt_pkg::OUT_ACTIVE_BIT] && !m_tdata[rlfrt_pkg::OUT_COUNT_BIT])
        else $error("release request with supervision still running");

    // The release cause is only set along with a release request.
    a_cause_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[rlfrt_pkg::OUT_CAUSE_BIT] |->
            m_tdata[rlfrt_pkg::OUT_REQ_BIT])
        else $error("release cause without release request");

    // A countdown only runs while supervision is on, and always has a cause.
    a_count_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[rlfrt_pkg::OUT_COUNT_BIT] |->
            m_tdata[rlfrt_pkg::OUT_ACTIVE_BIT] &&
            (m_tdata[rlfrt_pkg::OUT_STORED_LSB+1:rlfrt_pkg::OUT_STORED_LSB] !=
             rlfrt_pkg::CAUSE_NONE))
        else $error("countdown running without active supervision or cause");

    // A completed disable leaves nothing running.
    a_disable_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[rlfrt_pkg::OUT_DISDONE_BIT] |->
            !m_tdata[rlfrt_pkg::OUT_ACTIVE_BIT] && !m_tdata[rlfrt_pkg::OUT_COUNT_BIT] &&
            !m_tdata[rlfrt_pkg::OUT_REQ_BIT])
        else $error("disable left supervision active");

endmodule

bind radio_link_failure_release_timer_top rlfrt_checker u_rlfrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
